// ===== hdl/ddcu_pkg.sv =====
package ddcu_pkg;

    localparam logic [7:0] TAG_OK = 8'h10;

    localparam logic [7:0] CMD_DIR   = 8'h10;
    localparam logic [7:0] CMD_LEVEL = 8'h11;
    localparam logic [7:0] CMD_NOP_A = 8'h12;
    localparam logic [7:0] CMD_RAW   = 8'h14;
    localparam logic [7:0] CMD_NOP_B = 8'h15;

    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;

    localparam logic [2:0] LEVEL_MAX   = 3'd6;
    localparam logic [7:0] ANGLE_MAX   = 8'd180;
    localparam logic [7:0] ANGLE_MID   = 8'd90;
    localparam logic [7:0] FAST_MAX    = 8'd99;
    localparam logic [7:0] RAW_DUTY_RST = 8'd0;

    // The steering offset is floor(base * d * 2 / 225). The factor base * 2 / 225 is
    // folded into one fixed-point gain per level, rounded up, which is exact for d <= 90.
    localparam int GAIN_SHIFT = 16;
    localparam int GAIN_L1 = (2 * 10 * (1 << GAIN_SHIFT) + 224) / 225;
    localparam int GAIN_L2 = (2 * 25 * (1 << GAIN_SHIFT) + 224) / 225;
    localparam int GAIN_L3 = (2 * 30 * (1 << GAIN_SHIFT) + 224) / 225;
    localparam int GAIN_L4 = (2 * 45 * (1 << GAIN_SHIFT) + 224) / 225;
    localparam int GAIN_L5 = (2 * 60 * (1 << GAIN_SHIFT) + 224) / 225;

    typedef struct packed {
        logic [1:0] direction;
        logic [2:0] speed_level;
        logic [7:0] steer_angle;
        logic       drive_mode;
        logic [7:0] left_raw_duty;
        logic [7:0] right_raw_duty;
    } t_drive_state;

    typedef struct packed {
        logic [1:0] left_dir;
        logic [7:0] left_duty;
        logic [1:0] right_dir;
        logic [7:0] right_duty;
    } t_wheels;

    function automatic logic [7:0] f_base_speed(input logic [2:0] level);
        logic [7:0] base;
        case (level)
            3'd1:    base = 8'd10;
            3'd2:    base = 8'd25;
            3'd3:    base = 8'd30;
            3'd4:    base = 8'd45;
            3'd5:    base = 8'd60;
            default: base = 8'd0;
        endcase
        return base;
    endfunction

    function automatic logic [15:0] f_steer_gain(input logic [2:0] level);
        logic [15:0] gain;
        case (level)
            3'd1:    gain = 16'(GAIN_L1);
            3'd2:    gain = 16'(GAIN_L2);
            3'd3:    gain = 16'(GAIN_L3);
            3'd4:    gain = 16'(GAIN_L4);
            3'd5:    gain = 16'(GAIN_L5);
            default: gain = 16'd0;
        endcase
        return gain;
    endfunction

endpackage

// ===== hdl/ddcu_drive.sv =====
module ddcu_drive
    import ddcu_pkg::*;
(
    input  t_drive_state i_state,
    output t_wheels      o_wheels
);

    logic [1:0]  dir_code;
    logic [7:0]  t_angle;
    logic [7:0]  d_wide;
    logic [6:0]  d_abs;
    logic [7:0]  base;
    logic [15:0] gain;
    logic [22:0] prod;
    logic [6:0]  offset;
    logic [7:0]  slow;
    logic [7:0]  fast_sum;
    logic [7:0]  fast;

    assign dir_code = (i_state.direction == DIR_BACK) ? DIR_BACK : DIR_FWD;
    assign t_angle  = (i_state.direction == DIR_BACK) ? (ANGLE_MAX - i_state.steer_angle)
                                                      : i_state.steer_angle;
    assign d_wide   = (t_angle > ANGLE_MID) ? (t_angle - ANGLE_MID) : (ANGLE_MID - t_angle);
    assign d_abs    = d_wide[6:0];
    assign base     = f_base_speed(i_state.speed_level);
    assign gain     = f_steer_gain(i_state.speed_level);
    assign prod     = 23'(d_abs) * 23'(gain);
    assign offset   = prod[22:16];
    assign slow     = base - {1'b0, offset};
    assign fast_sum = base + {1'b0, offset};
    assign fast     = (fast_sum > FAST_MAX) ? FAST_MAX : fast_sum;

    always_comb begin
        o_wheels = '0;
        if (i_state.direction != DIR_STOP) begin
            if (!i_state.drive_mode) begin
                o_wheels.left_dir   = dir_code;
                o_wheels.right_dir  = dir_code;
                o_wheels.left_duty  = i_state.left_raw_duty;
                o_wheels.right_duty = i_state.right_raw_duty;
            end else if (i_state.speed_level != 3'd0) begin
                o_wheels.left_dir  = dir_code;
                o_wheels.right_dir = dir_code;
                if (t_angle > ANGLE_MID) begin
                    o_wheels.left_duty  = fast;
                    o_wheels.right_duty = slow;
                end else begin
                    o_wheels.left_duty  = slow;
                    o_wheels.right_duty = fast;
                end
            end
        end
    end

endmodule

// ===== hdl/differential_drive_command_unit.sv =====
// Motor command unit for a two-wheel differential drive.
// Command items enter on i_valid/o_ready with the fields i_frame_tag, i_mode and
// i_arg_a to i_arg_c. Each item yields exactly one result item on o_valid/i_ready:
// the echoed command code in o_status, and o_pwm_write with a direction and duty
// per wheel when the command issues new drive values.
// The enable switch is written on i_cfg_valid/o_cfg_ready, which is always ready.
// The user must write it only while no command is in flight; the unit does not enforce this.
// An item is captured in an input register, decoded combinationally against the stored
// drive state and placed in the result register, from which o_valid presents it.
// One item per cycle is sustained while the receiver takes results.
// The drive state is updated as each item moves into the result register.
// When the receiver stalls, the result register holds its item and the input
// register takes one more item before o_ready drops.
// Reset clears both registers, disables the unit, stops the wheels, sets the angle
// to straight ahead and selects speed level mode.
module differential_drive_command_unit
    import ddcu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_enable,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_frame_tag,
    input  logic [7:0] i_mode,
    input  logic [7:0] i_arg_a,
    input  logic [7:0] i_arg_b,
    input  logic [7:0] i_arg_c,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_status,
    output logic       o_pwm_write,
    output logic [1:0] o_left_dir,
    output logic [7:0] o_left_duty,
    output logic [1:0] o_right_dir,
    output logic [7:0] o_right_duty
);

    logic         r_enable;
    logic         r_in_valid;
    logic [7:0]   r_tag;
    logic [7:0]   r_mode;
    logic [7:0]   r_arg_a;
    logic [7:0]   r_arg_b;
    logic [7:0]   r_arg_c;
    t_drive_state r_state;
    t_drive_state n_state;
    logic         r_out_valid;
    logic [7:0]   r_status;
    logic [7:0]   n_status;
    logic         r_pwm_write;
    logic         n_pwm_write;
    t_wheels      r_wheels;
    t_wheels      n_wheels;
    t_wheels      drive_wheels;
    logic         advance;

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_status    = 8'd0;
        n_pwm_write = 1'b0;
        if (r_tag == TAG_OK) begin
            unique case (r_mode) inside
                CMD_DIR: begin
                    n_status = r_mode;
                    if (r_enable) begin
                        if (r_arg_a == 8'd0) begin
                            n_state.direction = DIR_STOP;
                        end else if (r_arg_a == 8'd1 || r_arg_a == 8'd2) begin
                            n_state.direction   = r_arg_a[1:0];
                            n_state.speed_level = 3'd0;
                        end
                        n_pwm_write = 1'b1;
                    end
                end
                CMD_LEVEL: begin
                    n_status = r_mode;
                    if (r_enable && r_arg_b <= 8'(LEVEL_MAX)) begin
                        n_state.drive_mode = 1'b1;
                        if (r_state.direction != DIR_STOP) begin
                            n_state.speed_level = r_arg_b[2:0];
                        end
                        if (r_arg_a <= ANGLE_MAX) begin
                            n_state.steer_angle = r_arg_a;
                        end
                        n_pwm_write = 1'b1;
                    end
                end
                CMD_RAW: begin
                    n_status = r_mode;
                    if (r_enable) begin
                        n_state.left_raw_duty  = r_arg_b;
                        n_state.right_raw_duty = r_arg_c;
                        n_state.drive_mode     = 1'b0;
                    end
                end
                CMD_NOP_A, CMD_NOP_B: begin
                    n_status = r_mode;
                end
                default: begin
                    n_status = 8'd0;
                end
            endcase
        end
        n_wheels = n_pwm_write ? drive_wheels : '0;
    end

    ddcu_drive u_drive (
        .i_state  (n_state),
        .o_wheels (drive_wheels)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state.direction      <= DIR_STOP;
            r_state.speed_level    <= 3'd0;
            r_state.steer_angle    <= ANGLE_MID;
            r_state.drive_mode     <= 1'b1;
            r_state.left_raw_duty  <= RAW_DUTY_RST;
            r_state.right_raw_duty <= RAW_DUTY_RST;
        end else begin
            if (i_cfg_valid) begin
                r_enable <= i_cfg_enable;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tag   <= i_frame_tag;
            r_mode  <= i_mode;
            r_arg_a <= i_arg_a;
            r_arg_b <= i_arg_b;
            r_arg_c <= i_arg_c;
        end
        if (advance) begin
            r_status    <= n_status;
            r_pwm_write <= n_pwm_write;
            r_wheels    <= n_wheels;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_pwm_write  = r_pwm_write;
    assign o_left_dir   = r_wheels.left_dir;
    assign o_left_duty  = r_wheels.left_duty;
    assign o_right_dir  = r_wheels.right_dir;
    assign o_right_duty = r_wheels.right_duty;

endmodule

// ===== test/tb_differential_drive_command_unit.sv =====
`timescale 1ns / 100ps

module tb_differential_drive_command_unit;
    import ddcu_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SCRIPT_LEN     = 27;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 42;

    typedef struct packed {
        logic [7:0] tag;
        logic [7:0] mode;
        logic [7:0] arg_a;
        logic [7:0] arg_b;
        logic [7:0] arg_c;
    } command_t;

    typedef struct packed {
        logic [7:0] status;
        logic       pwm_write;
        logic [1:0] left_dir;
        logic [7:0] left_duty;
        logic [1:0] right_dir;
        logic [7:0] right_duty;
    } drive_result_t;

    typedef enum logic [1:0] {
        ROW_SEND,
        ROW_SEND_CHECK,
        ROW_ENABLE
    } row_kind_e;

    typedef struct packed {
        row_kind_e     kind;
        command_t      cmd;
        drive_result_t want;
    } script_row_t;

    localparam drive_result_t UNCHECKED = '0;
    localparam command_t      NO_CMD    = '0;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_cfg_valid  = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_enable = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_ready;
    logic [7:0] i_frame_tag  = 8'd0;
    logic [7:0] i_mode       = 8'd0;
    logic [7:0] i_arg_a      = 8'd0;
    logic [7:0] i_arg_b      = 8'd0;
    logic [7:0] i_arg_c      = 8'd0;
    logic       o_valid;
    logic       i_ready      = 1'b0;
    logic [7:0] o_status;
    logic       o_pwm_write;
    logic [1:0] o_left_dir;
    logic [7:0] o_left_duty;
    logic [1:0] o_right_dir;
    logic [7:0] o_right_duty;

    logic       model_enable     = 1'b0;
    logic [1:0] model_dir        = DIR_STOP;
    logic [2:0] model_level      = 3'd0;
    logic [7:0] model_angle      = ANGLE_MID;
    logic       model_speed_mode = 1'b1;
    logic [7:0] model_left_raw   = RAW_DUTY_RST;
    logic [7:0] model_right_raw  = RAW_DUTY_RST;

    drive_result_t expected_results[$];
    script_row_t   script [SCRIPT_LEN];
    int            mismatches  = 0;
    int            idle_cycles = 0;
    bit            calm        = 1'b0;

    differential_drive_command_unit uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_enable (i_cfg_enable),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_frame_tag  (i_frame_tag),
        .i_mode       (i_mode),
        .i_arg_a      (i_arg_a),
        .i_arg_b      (i_arg_b),
        .i_arg_c      (i_arg_c),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_pwm_write  (o_pwm_write),
        .o_left_dir   (o_left_dir),
        .o_left_duty  (o_left_duty),
        .o_right_dir  (o_right_dir),
        .o_right_duty (o_right_duty)
    );

    always #5 i_clk = ~i_clk;

    function automatic drive_result_t quiet(input logic [7:0] code);
        drive_result_t res;
        res = '0;
        res.status = code;
        return res;
    endfunction

    function automatic drive_result_t wheels_off(input logic [7:0] code);
        drive_result_t res;
        res = quiet(code);
        res.pwm_write = 1'b1;
        return res;
    endfunction

    function automatic drive_result_t wheel_drive(input logic [7:0] code);
        drive_result_t res;
        int         base;
        int         t;
        int         d;
        int         off;
        int         fast;
        logic [1:0] dir;
        res = wheels_off(code);
        dir = (model_dir == DIR_BACK) ? DIR_BACK : DIR_FWD;
        if (model_dir != DIR_STOP) begin
            if (!model_speed_mode) begin
                res.left_dir   = dir;
                res.right_dir  = dir;
                res.left_duty  = model_left_raw;
                res.right_duty = model_right_raw;
            end else if (model_level != 3'd0) begin
                case (model_level)
                    3'd1:    base = 10;
                    3'd2:    base = 25;
                    3'd3:    base = 30;
                    3'd4:    base = 45;
                    3'd5:    base = 60;
                    default: base = 0;
                endcase
                t = (model_dir == DIR_BACK) ? int'(ANGLE_MAX) - int'(model_angle)
                                            : int'(model_angle);
                d = (t > int'(ANGLE_MID)) ? t - int'(ANGLE_MID) : int'(ANGLE_MID) - t;
                off = base * d * 2 / 225;
                fast = (base + off > int'(FAST_MAX)) ? int'(FAST_MAX) : base + off;
                res.left_dir  = dir;
                res.right_dir = dir;
                if (t > int'(ANGLE_MID)) begin
                    res.left_duty  = 8'(fast);
                    res.right_duty = 8'(base - off);
                end else begin
                    res.left_duty  = 8'(base - off);
                    res.right_duty = 8'(fast);
                end
            end
        end
        return res;
    endfunction

    function automatic drive_result_t apply_command(input command_t cmd);
        drive_result_t res;
        res = '0;
        if (cmd.tag == TAG_OK) begin
            case (cmd.mode)
                CMD_DIR: begin
                    res = quiet(cmd.mode);
                    if (model_enable) begin
                        if (cmd.arg_a == 8'd0) begin
                            model_dir = DIR_STOP;
                        end else if (cmd.arg_a == 8'd1 || cmd.arg_a == 8'd2) begin
                            model_dir   = (cmd.arg_a == 8'd1) ? DIR_FWD : DIR_BACK;
                            model_level = 3'd0;
                        end
                        res = wheel_drive(cmd.mode);
                    end
                end
                CMD_LEVEL: begin
                    res = quiet(cmd.mode);
                    if (model_enable && cmd.arg_b <= LEVEL_MAX) begin
                        model_speed_mode = 1'b1;
                        if (model_dir != DIR_STOP) begin
                            model_level = cmd.arg_b[2:0];
                        end
                        if (cmd.arg_a <= ANGLE_MAX) begin
                            model_angle = cmd.arg_a;
                        end
                        res = wheel_drive(cmd.mode);
                    end
                end
                CMD_RAW: begin
                    res = quiet(cmd.mode);
                    if (model_enable) begin
                        model_left_raw   = cmd.arg_b;
                        model_right_raw  = cmd.arg_c;
                        model_speed_mode = 1'b0;
                    end
                end
                CMD_NOP_A, CMD_NOP_B: begin
                    res = quiet(cmd.mode);
                end
                default: begin
                end
            endcase
        end
        return res;
    endfunction

    function automatic command_t random_command();
        command_t cmd;
        int       pick;
        cmd.tag   = ($urandom_range(9) == 0) ? 8'($urandom) : TAG_OK;
        cmd.arg_a = 8'($urandom);
        cmd.arg_b = 8'($urandom);
        cmd.arg_c = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) begin
            cmd.mode = CMD_DIR;
            pick = $urandom_range(99);
            if (pick < 60) begin
                cmd.arg_a = 8'($urandom_range(2, 1));
            end else if (pick < 85) begin
                cmd.arg_a = 8'd0;
            end
        end else if (pick < 75) begin
            cmd.mode = CMD_LEVEL;
            if ($urandom_range(9) != 0) begin
                cmd.arg_a = 8'($urandom_range(int'(ANGLE_MAX)));
            end
            if ($urandom_range(9) != 0) begin
                cmd.arg_b = 8'($urandom_range(int'(LEVEL_MAX)));
            end
        end else if (pick < 85) begin
            cmd.mode = CMD_RAW;
        end else if (pick < 90) begin
            cmd.mode = CMD_NOP_A;
        end else if (pick < 95) begin
            cmd.mode = CMD_NOP_B;
        end else begin
            cmd.mode = 8'($urandom);
        end
        return cmd;
    endfunction

    task automatic send_command(input command_t cmd, input bit typed,
                                input drive_result_t want);
        drive_result_t predicted;
        while (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_frame_tag <= cmd.tag;
        i_mode      <= cmd.mode;
        i_arg_a     <= cmd.arg_a;
        i_arg_b     <= cmd.arg_b;
        i_arg_c     <= cmd.arg_c;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predicted = apply_command(cmd);
        expected_results.push_back(typed ? want : predicted);
    endtask

    task automatic write_enable(input logic value);
        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (3) @(posedge i_clk);
        i_cfg_valid  <= 1'b1;
        i_cfg_enable <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid  <= 1'b0;
        model_enable = value;
    endtask

    task automatic compare_result(input drive_result_t want);
        if (o_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, o_status);
            mismatches++;
        end
        if (o_pwm_write !== want.pwm_write) begin
            $error("pwm_write: expected %0d, actual %0d", want.pwm_write, o_pwm_write);
            mismatches++;
        end
        if (o_left_dir !== want.left_dir) begin
            $error("left_dir: expected %0d, actual %0d", want.left_dir, o_left_dir);
            mismatches++;
        end
        if (o_left_duty !== want.left_duty) begin
            $error("left_duty: expected %0d, actual %0d", want.left_duty, o_left_duty);
            mismatches++;
        end
        if (o_right_dir !== want.right_dir) begin
            $error("right_dir: expected %0d, actual %0d", want.right_dir, o_right_dir);
            mismatches++;
        end
        if (o_right_duty !== want.right_duty) begin
            $error("right_duty: expected %0d, actual %0d", want.right_duty, o_right_duty);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        i_ready <= calm || ($urandom_range(99) >= 25);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result item with no expectation waiting, status %0d", o_status);
                mismatches++;
            end else begin
                compare_result(expected_results.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_differential_drive_command_unit: done, errors");
            $finish;
        end
    end

    initial begin
        int row;
        int phase;
        int n;
        script = '{
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_DIR, 8'd1, 8'd0, 8'd0}, quiet(CMD_DIR)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_RAW, 8'd0, 8'd5, 8'd6}, quiet(CMD_RAW)},
            '{ROW_SEND_CHECK, '{8'h00, CMD_DIR, 8'd1, 8'd0, 8'd0}, quiet(8'd0)},
            '{ROW_ENABLE, NO_CMD, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_DIR, 8'd0, 8'd0, 8'd0}, wheels_off(CMD_DIR)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_LEVEL, 8'd90, 8'd3, 8'd0}, wheels_off(CMD_LEVEL)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_DIR, 8'd1, 8'd0, 8'd0}, wheels_off(CMD_DIR)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_LEVEL, 8'd90, 8'd5, 8'd0},
              '{CMD_LEVEL, 1'b1, DIR_FWD, 8'd60, DIR_FWD, 8'd60}},
            '{ROW_SEND, '{TAG_OK, CMD_LEVEL, 8'd180, 8'd5, 8'd0}, UNCHECKED},
            '{ROW_SEND, '{TAG_OK, CMD_LEVEL, 8'd0, 8'd1, 8'd0}, UNCHECKED},
            '{ROW_SEND, '{TAG_OK, CMD_LEVEL, 8'd200, 8'd2, 8'd0}, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_LEVEL, 8'd45, 8'd7, 8'd0}, quiet(CMD_LEVEL)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_LEVEL, 8'd255, 8'd255, 8'd0}, quiet(CMD_LEVEL)},
            '{ROW_SEND, '{TAG_OK, CMD_LEVEL, 8'd120, 8'd6, 8'd0}, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_DIR, 8'd2, 8'd0, 8'd0}, wheels_off(CMD_DIR)},
            '{ROW_SEND, '{TAG_OK, CMD_LEVEL, 8'd30, 8'd4, 8'd0}, UNCHECKED},
            '{ROW_SEND, '{TAG_OK, CMD_DIR, 8'd3, 8'd0, 8'd0}, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_RAW, 8'd0, 8'd255, 8'd0}, quiet(CMD_RAW)},
            '{ROW_SEND, '{TAG_OK, CMD_DIR, 8'd255, 8'd0, 8'd0}, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_RAW, 8'd0, 8'd0, 8'd255}, quiet(CMD_RAW)},
            '{ROW_SEND, '{TAG_OK, CMD_DIR, 8'd1, 8'd0, 8'd0}, UNCHECKED},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_DIR, 8'd0, 8'd0, 8'd0}, wheels_off(CMD_DIR)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_LEVEL, 8'd100, 8'd2, 8'd0}, wheels_off(CMD_LEVEL)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_NOP_A, 8'd7, 8'd7, 8'd7}, quiet(CMD_NOP_A)},
            '{ROW_SEND_CHECK, '{TAG_OK, CMD_NOP_B, 8'd0, 8'd0, 8'd0}, quiet(CMD_NOP_B)},
            '{ROW_SEND_CHECK, '{8'hFF, CMD_LEVEL, 8'd255, 8'd255, 8'd255}, quiet(8'd0)},
            '{ROW_SEND_CHECK, '{TAG_OK, 8'hFF, 8'd1, 8'd1, 8'd1}, quiet(8'd0)}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < SCRIPT_LEN; row++) begin
            case (script[row].kind)
                ROW_ENABLE:     write_enable(1'b1);
                ROW_SEND_CHECK: send_command(script[row].cmd, 1'b1, script[row].want);
                default:        send_command(script[row].cmd, 1'b0, UNCHECKED);
            endcase
        end

        // The unit is switched off for two of the phases, and one phase runs with
        // both sides streaming at full rate.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_enable(phase % 4 != 2);
            calm = (phase == 4);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_command(random_command(), 1'b0, UNCHECKED);
            end
        end
        calm = 1'b0;

        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_differential_drive_command_unit: done, clean");
        end else begin
            $display("tb_differential_drive_command_unit: done, errors");
        end
        $finish;
    end

endmodule
